FILE: rtl/core/wfc_pkg.sv
// Package for the word frequency counter: sizes, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package wfc_pkg;
  localparam int MaxWordLenDef = 16;
  localparam int TableDepthDef = 16;
  localparam int CntW          = 16;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_CMP,
    S_HIT,
    S_APPEND,
    S_DONE
  } state_e;

  // Fold a letter to lower case; report whether the byte is a letter.
  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction
endpackage

FILE: rtl/core/wfc_ram.sv
// Character store of the word table: one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module wfc_ram #(
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  logic [7:0] mem_q [Depth];

  // Write and read in one clocked block.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/core/word_frequency_counter.sv
// Top level of the word frequency counter: byte intake, word buffer, sequencer,
// table search over a shared byte comparator. Depends on wfc_pkg and wfc_ram.
//
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+-------------------------
//  input     | start_i, busy_o, ch_i, last_i           | start_i && !busy_o
//  result    | valid_o, entry_index_o .. end_of_sentence_o | valid_o, one cycle
//
// A letter that does not end a word is taken in S_IDLE; a word end goes to S_LEN
// to check its length, then S_CMP searches: an entry of another length is skipped,
// one of the same length is read, then compared, byte by byte; an empty table goes
// straight to S_APPEND. S_HIT counts a hit; S_APPEND reports a full table or
// writes the word byte by byte; S_DONE closes. A too-long word skips the search.
// Reset clears counts and control; the table is empty after reset and after
// every last byte. The receiver cannot stall; results are shown one cycle.
`timescale 1ns / 1ps
module word_frequency_counter
  import wfc_pkg::*;
#(
  parameter int MaxWordLen = MaxWordLenDef,
  parameter int TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        valid_o,
  output logic [3:0]  entry_index_o,
  output logic        new_word_o,
  output logic [15:0] entry_count_o,
  output logic [15:0] total_words_o,
  output logic [4:0]  distinct_words_o,
  output logic [1:0]  status_o,
  output logic        end_of_sentence_o
);
  localparam int LenW = $clog2(MaxWordLen + 2);
  localparam int CharW = $clog2(MaxWordLen);
  localparam int EntW = $clog2(TableDepth);
  localparam int DistW = $clog2(TableDepth + 1);
  localparam int MemAW = $clog2(TableDepth * MaxWordLen);
  localparam int MemD = TableDepth * MaxWordLen;
  localparam logic [LenW-1:0] LenMax = LenW'(MaxWordLen);
  localparam logic [DistW-1:0] DistFull = DistW'(TableDepth);

  state_e state_q, state_d;
  logic [7:0]       cur_q [MaxWordLen];
  logic [LenW-1:0]  len_q, len_d;
  logic             in_word_q, in_word_d;
  logic [LenW-1:0]  tlen_q [TableDepth];
  logic [CntW-1:0]  tcnt_q [TableDepth];
  logic [CntW-1:0]  total_q, total_d;
  logic [DistW-1:0] dist_q, dist_d;
  logic [EntW-1:0]  ent_q, ent_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic             rd_q, rd_d;
  logic             eos_q, eos_d;
  logic             cur_we;
  logic [CntW-1:0]  cnt_new;
  logic             mem_we;
  logic [MemAW-1:0] mem_wa, mem_ra;
  logic [7:0]       mem_rd, mem_wd;
  logic             tab_we, cnt_we;
  logic             res_v;
  logic [3:0]       res_idx;
  logic             res_new;
  logic [CntW-1:0]  res_cnt;
  status_e          res_st;
  logic             accept, letter, close;
  logic [7:0]       lc;

  assign accept = start_i && !busy_o;
  assign letter = is_letter(ch_i);
  assign lc     = to_lower(ch_i);
  assign close  = (in_word_q || letter) && (!letter || last_i);
  assign busy_o = (state_q != S_IDLE);

  function automatic logic [MemAW-1:0] maddr(input logic [EntW-1:0] e,
                                             input logic [LenW-1:0] p);
    logic [MemAW+LenW-1:0] a;
    a = (MemAW+LenW)'(e) * (MemAW+LenW)'(MaxWordLen) + (MemAW+LenW)'(p);
    maddr = a[MemAW-1:0];
  endfunction

  wfc_ram #(.Depth(MemD), .AddrW(MemAW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  assign cnt_new = (tcnt_q[ent_q] == CntMax) ? CntMax : tcnt_q[ent_q] + 1'b1;

  // Control registers with asynchronous reset: state, word length, counts, valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      in_word_q <= 1'b0;
      total_q   <= '0;
      dist_q    <= '0;
      rd_q      <= 1'b0;
      eos_q     <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      in_word_q <= in_word_d;
      total_q   <= total_d;
      dist_q    <= dist_d;
      rd_q      <= rd_d;
      eos_q     <= eos_d;
      valid_o   <= res_v;
    end
  end

  // Payload registers: word buffer, table side arrays, result fields.
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    pos_q <= pos_d;
    if (cur_we) begin
      cur_q[len_q[CharW-1:0]] <= lc;
    end
    if (tab_we) begin
      tlen_q[ent_q] <= len_q;
      tcnt_q[ent_q] <= CntW'(1);
    end
    if (cnt_we) begin
      tcnt_q[ent_q] <= cnt_new;
    end
    if (res_v) begin
      entry_index_o     <= res_idx;
      new_word_o        <= res_new;
      entry_count_o     <= res_cnt;
      total_words_o     <= total_q;
      distinct_words_o  <= 5'(dist_d);
      status_o          <= res_st;
      end_of_sentence_o <= eos_q;
    end
  end

  // Sequence intake, search and append.
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    in_word_d = in_word_q;
    total_d   = total_q;
    dist_d    = dist_q;
    ent_d     = ent_q;
    pos_d     = pos_q;
    rd_d      = 1'b0;
    eos_d     = eos_q;
    cur_we    = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = maddr(ent_q, pos_q);
    mem_wd    = cur_q[pos_q[CharW-1:0]];
    mem_ra    = maddr(ent_q, pos_q);
    tab_we    = 1'b0;
    cnt_we    = 1'b0;
    res_v     = 1'b0;
    res_idx   = 4'(ent_q);
    res_new   = 1'b0;
    res_cnt   = '0;
    res_st    = ST_COUNTED;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          eos_d = last_i;
          if (letter) begin
            if (!in_word_q) begin
              in_word_d = 1'b1;
              len_d     = LenW'(1);
              pos_d     = '0;
              cur_we    = 1'b1;
            end else begin
              cur_we = (len_q < LenMax);
              if (len_q <= LenMax) begin
                len_d = len_q + 1'b1;
              end
            end
          end
          if (close) begin
            state_d = S_LEN;
            total_d = (total_q == CntMax) ? CntMax : total_q + 1'b1;
          end else if (last_i) begin
            state_d = S_DONE;
          end
        end
      end
      S_LEN: begin
        ent_d = '0;
        pos_d = '0;
        if (len_q > LenMax) begin
          res_v   = 1'b1;
          res_idx = '0;
          res_st  = ST_TOO_LONG;
          state_d = S_DONE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // Walk entries; read each byte, then compare it.
        if ({1'b0, ent_q} >= (EntW+1)'(dist_q) || dist_q == '0 ||
            (ent_q == '0 && pos_q == '0 && !rd_q && dist_q == '0)) begin
          state_d = S_APPEND;
        end else if (tlen_q[ent_q] != len_q ||
                     (rd_q && mem_rd != cur_q[pos_q[CharW-1:0]])) begin
          pos_d = '0;
          ent_d = ent_q + 1'b1;
          if ({1'b0, ent_q} == (EntW+1)'(dist_q - 1'b1)) begin
            state_d = S_APPEND;
          end
        end else if (rd_q) begin
          if (pos_q + 1'b1 == len_q) begin
            state_d = S_HIT;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end else begin
          rd_d = 1'b1;
        end
      end
      S_HIT: begin
        cnt_we  = 1'b1;
        res_v   = 1'b1;
        res_cnt = cnt_new;
        state_d = S_DONE;
      end
      S_APPEND: begin
        if (dist_q == DistFull) begin
          res_v   = 1'b1;
          res_idx = '0;
          res_st  = ST_FULL;
          state_d = S_DONE;
        end else begin
          ent_d  = EntW'(dist_q);
          mem_we = (pos_q < len_q);
          mem_wa = maddr(EntW'(dist_q), pos_q);
          pos_d  = pos_q + 1'b1;
          if (pos_q + 1'b1 >= len_q) begin
            tab_we  = 1'b1;
            dist_d  = dist_q + 1'b1;
            res_v   = 1'b1;
            res_idx = 4'(dist_q);
            res_new = 1'b1;
            res_cnt = CntW'(1);
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        in_word_d = 1'b0;
        len_d     = '0;
        if (eos_q) begin
          total_d = '0;
          dist_d  = '0;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  p_busy_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && close |=> busy_o) else $error("word end did not start a search");
  p_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= DistFull) else $error("distinct count beyond table depth");
  p_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result held past one cycle");
  p_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> state_q == S_DONE) else $error("result outside final step");
endmodule

FILE: verif/tb_top.sv
// Testbench for word_frequency_counter: directed table, long-word and full-table
// phases, then random text, checked against a local predictor or typed rows.
// Depends on wfc_pkg and the word_frequency_counter RTL.
`timescale 1ns / 1ps
module tb_top
  import wfc_pkg::*;
();

  localparam int WordLen  = MaxWordLenDef;
  localparam int Depth    = TableDepthDef;
  localparam int Drain    = 700;
  localparam int IdleMax  = 6000;
  localparam logic [7:0] Space = 8'h20;

  typedef struct packed {
    logic [3:0]  idx;
    logic        fresh;
    logic [15:0] cnt;
    logic [15:0] tot;
    logic [4:0]  ndist;
    status_e     st;
    logic        eos;
  } word_result_t;

  typedef struct {
    logic [7:0]   ch;
    logic         last;
    bit           typed;
    word_result_t res;
  } text_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [7:0]  ch_i = '0;
  logic        last_i = 1'b0;
  logic        busy_o, valid_o, new_word_o, end_of_sentence_o;
  logic [3:0]  entry_index_o;
  logic [15:0] entry_count_o, total_words_o;
  logic [4:0]  distinct_words_o;
  logic [1:0]  status_o;

  word_frequency_counter u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state
  logic [7:0]  word_buf [WordLen];
  int          word_len;
  bit          word_open;
  logic [7:0]  dict_chars [Depth][WordLen];
  int          dict_len [Depth];
  int          dict_cnt [Depth];
  int          seen_total;
  int          dict_size;

  word_result_t pending_q[$];
  int  errors = 0;
  bit  gaps_on = 1'b1;
  int  idle_cycles = 0;

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void clear_dict();
    word_len = 0;
    word_open = 0;
    seen_total = 0;
    dict_size = 0;
  endfunction

  // Advance the predictor by one byte; return 1 when a word closes.
  function automatic bit count_byte(input logic [7:0] c, input logic l,
                                    output word_result_t r);
    bit letter, hit, same;
    logic [7:0] lc;
    letter = is_alpha(c);
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    hit = 0;
    r = '0;
    if (letter) begin
      if (!word_open) begin
        word_open = 1;
        word_len = 0;
      end
      if (word_len < WordLen) word_buf[word_len] = lc;
      if (word_len <= WordLen) word_len++;
    end
    if (word_open && (!letter || l)) begin
      if (seen_total < 65535) seen_total++;
      r.st = ST_COUNTED;
      if (word_len > WordLen) begin
        r.st = ST_TOO_LONG;
      end else begin
        for (int e = 0; e < dict_size && !hit; e++) begin
          same = (dict_len[e] == word_len);
          for (int i = 0; i < word_len && same; i++)
            if (dict_chars[e][i] != word_buf[i]) same = 0;
          if (same) begin
            hit = 1;
            if (dict_cnt[e] < 65535) dict_cnt[e]++;
            r.idx = 4'(e);
            r.cnt = 16'(dict_cnt[e]);
          end
        end
        if (!hit) begin
          if (dict_size < Depth) begin
            for (int i = 0; i < word_len; i++) dict_chars[dict_size][i] = word_buf[i];
            dict_len[dict_size] = word_len;
            dict_cnt[dict_size] = 1;
            r.idx = 4'(dict_size);
            r.cnt = 16'd1;
            r.fresh = 1'b1;
            dict_size++;
          end else begin
            r.st = ST_FULL;
          end
        end
      end
      r.tot = 16'(seen_total);
      r.ndist = 5'(dict_size);
      r.eos = l;
      word_open = 0;
      word_len = 0;
      hit = 1;
    end
    if (l) clear_dict();
    return hit;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Hold the byte until the transfer, then predict and idle a while.
  task automatic send_byte(input logic [7:0] c, input logic l,
                           input bit typed = 0, input word_result_t want = '0);
    word_result_t r;
    int gap;
    ch_i <= c;
    last_i <= l;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (count_byte(c, l, r)) pending_q.push_back(typed ? want : r);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter(input int span);
    logic [7:0] b;
    b = 8'("a" + $urandom_range(span - 1));
    return $urandom_range(1) ? b - 8'd32 : b;
  endfunction

  function automatic logic [7:0] rand_sep();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_alpha(b));
    return b;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    word_result_t w;
    if (valid_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual index %0d", $time,
                 entry_index_o);
        errors++;
      end else begin
        w = pending_q.pop_front();
        report_field("entry_index", w.idx, entry_index_o);
        report_field("new_word", w.fresh, new_word_o);
        report_field("entry_count", w.cnt, entry_count_o);
        report_field("total_words", w.tot, total_words_o);
        report_field("distinct_words", w.ndist, distinct_words_o);
        report_field("status", w.st, status_o);
        report_field("end_of_sentence", w.eos, end_of_sentence_o);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleMax) begin
      $display("status: fail");
      $finish;
    end
  end

  text_row_t rows[$];

  function automatic word_result_t mk(input int idx, input int fresh, input int cnt,
                                      input int tot, input int dist_n, input status_e st,
                                      input int eos);
    word_result_t r;
    r.idx = 4'(idx); r.fresh = 1'(fresh); r.cnt = 16'(cnt); r.tot = 16'(tot);
    r.ndist = 5'(dist_n); r.st = st; r.eos = 1'(eos);
    return r;
  endfunction

  initial begin
    int n, len, span;
    clear_dict();
    // Directed text: case folding, range edges of letters, separators, last
    rows = '{
      '{8'h48, 0, 0, '0}, '{8'h69, 0, 0, '0},
      '{Space, 0, 1, mk(0, 1, 1, 1, 1, ST_COUNTED, 0)},
      '{8'h68, 0, 0, '0}, '{8'h49, 0, 0, '0},
      '{8'h00, 0, 1, mk(0, 0, 2, 2, 1, ST_COUNTED, 0)},
      '{8'h40, 0, 0, '0},
      '{8'h41, 0, 0, '0}, '{8'h5A, 0, 0, '0}, '{8'h5B, 0, 0, '0},
      '{8'h60, 0, 0, '0}, '{8'h61, 0, 0, '0}, '{8'h7A, 0, 0, '0},
      '{8'h7B, 0, 0, '0}, '{8'hFF, 0, 0, '0},
      '{8'h7A, 1, 1, mk(2, 1, 1, 5, 3, ST_COUNTED, 1)},
      '{8'h80, 1, 0, '0},
      '{8'h61, 0, 0, '0},
      '{8'h2E, 1, 1, mk(0, 1, 1, 1, 1, ST_COUNTED, 1)},
      '{8'h7F, 0, 0, '0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_byte(rows[i].ch, rows[i].last, rows[i].typed, rows[i].res);

    // Long words: exactly the buffer, one over, well over, then a repeat
    send_word("abcdefghijklmnop"); send_byte(Space, 0);
    send_word("abcdefghijklmnopq"); send_byte(Space, 0);
    send_word("ABCDEFGHIJKLMNOPQRST"); send_byte(Space, 0);
    send_word("abcdefghijklmnop"); send_byte(8'h2C, 1);

    // Fill the table, overflow it, hit a stored entry
    for (int i = 0; i < Depth + 2; i++) begin
      send_byte("q", 0); send_byte(8'("a" + i), 0); send_byte(Space, 0);
    end
    send_byte("q", 0); send_byte("c", 1);

    // Hold the sender until every result is in before the random text
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);

    // Random text: mostly words from a small alphabet, some noise bytes
    n = 0;
    while (n < 1000) begin
      if (n > 400 && n < 700) gaps_on = 0;
      else gaps_on = 1;
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        n++;
      end else begin
        span = $urandom_range(3) == 0 ? 26 : 3;
        len = $urandom_range(9) == 0 ? $urandom_range(20, 1) : $urandom_range(4, 1);
        for (int i = 0; i < len; i++) begin
          send_byte(rand_letter(span), (i == len - 1) && $urandom_range(24) == 0);
          n++;
        end
        send_byte(rand_sep(), $urandom_range(30) == 0);
        n++;
      end
    end
    start_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
